// ===== sv/hs_pkg.sv =====
package hs_pkg;

    // Width of one value and default store depth
    localparam int DATA_W        = 32;
    localparam int MAX_ITEMS_DEF = 64;

    typedef logic signed [DATA_W-1:0] t_word;

    // Outcome of one sift-down comparison
    typedef struct packed {
        logic pick_right;   // right child is the larger child
        logic swap;         // larger child beats the carried value
    } t_cmp_res;

endpackage

// ===== sv/heap_sorter.sv =====
// Channel  | Dir | Beat contents
// ---------+-----+----------------------------------------------------------
// s_axis   | in  | tdata[31:0] value (signed), tlast marks last value of a set
// m_axis   | out | tdata[31:0] sorted value, tlast final result, tuser overflow
//
// Loading accepts one beat per cycle. On the last beat the held set of n values
// is heapified and heap-sorted in place by one shared compare unit: each
// sift-down level reads the children, then compares and writes; each sift is
// started by fetching its carried value and ends with the write of that value.
// Results then leave at one per cycle while m_axis_tready is high.
// Reset is synchronous, active low, and clears the count and overflow mark;
// s_axis_tready is low from the last beat until the final result is taken,
// and a stalled result simply holds.
module heap_sorter #(
    parameter int MAX_ITEMS = hs_pkg::MAX_ITEMS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [hs_pkg::DATA_W-1:0] s_axis_tdata,   // [31:0] value
    input  logic                      s_axis_tlast,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [hs_pkg::DATA_W-1:0] m_axis_tdata,   // [31:0] sorted_value
    output logic                      m_axis_tlast,
    output logic                      m_axis_tuser    // [0] overflow
);

    localparam int IDX_W = $clog2(MAX_ITEMS);
    localparam int CNT_W = $clog2(MAX_ITEMS + 1);
    localparam int CH_W  = IDX_W + 2;

    typedef enum logic [7:0] {
        ST_LOAD    = 8'b0000_0001,
        ST_NEXT    = 8'b0000_0010,
        ST_BLD_CUR = 8'b0000_0100,
        ST_EXT_SWP = 8'b0000_1000,
        ST_SFT_RD  = 8'b0001_0000,
        ST_SFT_CMP = 8'b0010_0000,
        ST_EMIT    = 8'b0100_0000
    } t_state;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               r_drop, n_drop;
    logic               r_bld, n_bld;
    logic [CNT_W-1:0]   r_iter, n_iter;
    logic [CNT_W-1:0]   r_size, n_size;
    logic [IDX_W-1:0]   r_root, n_root;
    logic [IDX_W-1:0]   r_left, n_left;
    logic               r_right_ok, n_right_ok;
    hs_pkg::t_word      r_cur, n_cur;
    logic [IDX_W-1:0]   r_k, n_k;

    logic               w_we;
    logic [IDX_W-1:0]   w_waddr;
    hs_pkg::t_word      w_wdata;
    logic               w_re_a;
    logic [IDX_W-1:0]   w_addr_a;
    logic               w_re_b;
    logic [IDX_W-1:0]   w_addr_b;
    hs_pkg::t_word      w_rd_a;
    hs_pkg::t_word      w_rd_b;
    hs_pkg::t_cmp_res   w_res;

    logic               w_s_acc;
    logic               w_m_acc;
    logic [CH_W-1:0]    w_left2;
    logic [CH_W-1:0]    w_right2;
    logic [CH_W-1:0]    w_size2;
    logic               w_left_ok;
    logic               w_right_ok;
    logic               w_room;
    logic [CNT_W-1:0]   w_n;
    logic               w_last_out;
    hs_pkg::t_word      w_child;
    logic [IDX_W-1:0]   w_child_idx;

    hs_store #(
        .DEPTH (MAX_ITEMS)
    ) u_store (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_waddr),
        .i_wdata   (w_wdata),
        .i_re_a    (w_re_a),
        .i_raddr_a (w_addr_a),
        .o_rdata_a (w_rd_a),
        .i_re_b    (w_re_b),
        .i_raddr_b (w_addr_b),
        .o_rdata_b (w_rd_b)
    );

    hs_cmp u_cmp (
        .i_left     (w_rd_a),
        .i_right    (w_rd_b),
        .i_cur      (r_cur),
        .i_right_ok (r_right_ok),
        .o_res      (w_res)
    );

    // Handshakes
    assign w_s_acc = s_axis_tvalid && s_axis_tready;
    assign w_m_acc = m_axis_tvalid && m_axis_tready;

    // Children of the current root and their bounds
    assign w_left2    = {1'b0, r_root, 1'b1};
    assign w_right2   = w_left2 + CH_W'(1);
    assign w_size2    = CH_W'(r_size);
    assign w_left_ok  = w_left2 < w_size2;
    assign w_right_ok = w_right2 < w_size2;

    assign w_child     = w_res.pick_right ? w_rd_b : w_rd_a;
    assign w_child_idx = w_res.pick_right ? r_left + IDX_W'(1) : r_left;

    // Store occupancy
    assign w_room = r_count < CNT_W'(MAX_ITEMS);
    assign w_n    = w_room ? r_count + CNT_W'(1) : r_count;

    assign w_last_out = (CNT_W'(r_k) + CNT_W'(1)) == r_count;

    // Sequencer
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_drop     = r_drop;
        n_bld      = r_bld;
        n_iter     = r_iter;
        n_size     = r_size;
        n_root     = r_root;
        n_left     = r_left;
        n_right_ok = r_right_ok;
        n_cur      = r_cur;
        n_k        = r_k;
        w_we       = 1'b0;
        w_waddr    = r_root;
        w_wdata    = r_cur;
        w_re_a     = 1'b0;
        w_addr_a   = '0;
        w_re_b     = 1'b0;
        w_addr_b   = '0;

        unique case (r_state)
            ST_LOAD: begin
                if (w_s_acc) begin
                    if (w_room) begin
                        w_we    = 1'b1;
                        w_waddr = r_count[IDX_W-1:0];
                        w_wdata = s_axis_tdata;
                        n_count = w_n;
                    end else begin
                        n_drop = 1'b1;
                    end
                    if (s_axis_tlast) begin
                        n_iter  = w_n >> 1;
                        n_bld   = 1'b1;
                        n_state = ST_NEXT;
                    end
                end
            end
            ST_NEXT: begin
                if (r_bld) begin
                    // heapify: next internal node, bottom up
                    if (r_iter != '0) begin
                        n_root   = IDX_W'(r_iter - CNT_W'(1));
                        w_re_a   = 1'b1;
                        w_addr_a = IDX_W'(r_iter - CNT_W'(1));
                        n_iter   = r_iter - CNT_W'(1);
                        n_state  = ST_BLD_CUR;
                    end else begin
                        n_bld  = 1'b0;
                        n_iter = r_count;
                    end
                end else if (r_iter > CNT_W'(1)) begin
                    // extract: fetch top and last of the heap
                    w_re_a   = 1'b1;
                    w_addr_a = '0;
                    w_re_b   = 1'b1;
                    w_addr_b = IDX_W'(r_iter - CNT_W'(1));
                    n_size   = r_iter - CNT_W'(1);
                    n_iter   = r_iter - CNT_W'(1);
                    n_state  = ST_EXT_SWP;
                end else begin
                    w_re_a   = 1'b1;
                    w_addr_a = '0;
                    n_k      = '0;
                    n_state  = ST_EMIT;
                end
            end
            ST_BLD_CUR: begin
                n_cur   = w_rd_a;
                n_size  = r_count;
                n_state = ST_SFT_RD;
            end
            ST_EXT_SWP: begin
                // old top goes to the end, old end is carried down from the root
                n_cur   = w_rd_b;
                w_we    = 1'b1;
                w_waddr = IDX_W'(r_size);
                w_wdata = w_rd_a;
                n_root  = '0;
                n_state = ST_SFT_RD;
            end
            ST_SFT_RD: begin
                if (w_left_ok) begin
                    w_re_a     = 1'b1;
                    w_addr_a   = w_left2[IDX_W-1:0];
                    w_re_b     = w_right_ok;
                    w_addr_b   = w_right2[IDX_W-1:0];
                    n_left     = w_left2[IDX_W-1:0];
                    n_right_ok = w_right_ok;
                    n_state    = ST_SFT_CMP;
                end else begin
                    w_we    = 1'b1;
                    n_state = ST_NEXT;
                end
            end
            ST_SFT_CMP: begin
                w_we = 1'b1;
                if (w_res.swap) begin
                    // child moves up into the hole
                    w_wdata = w_child;
                    n_root  = w_child_idx;
                    n_state = ST_SFT_RD;
                end else begin
                    n_state = ST_NEXT;
                end
            end
            ST_EMIT: begin
                if (w_m_acc) begin
                    if (w_last_out) begin
                        n_count = '0;
                        n_drop  = 1'b0;
                        n_state = ST_LOAD;
                    end else begin
                        n_k      = r_k + IDX_W'(1);
                        w_re_a   = 1'b1;
                        w_addr_a = r_k + IDX_W'(1);
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_count <= '0;
            r_drop  <= 1'b0;
            r_bld   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_drop  <= n_drop;
            r_bld   <= n_bld;
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_iter     <= n_iter;
        r_size     <= n_size;
        r_root     <= n_root;
        r_left     <= n_left;
        r_right_ok <= n_right_ok;
        r_cur      <= n_cur;
        r_k        <= n_k;
    end

    // Ports
    assign s_axis_tready = r_state == ST_LOAD;
    assign m_axis_tvalid = r_state == ST_EMIT;
    assign m_axis_tdata  = w_rd_a;
    assign m_axis_tlast  = w_last_out;
    assign m_axis_tuser  = r_drop;

endmodule

// ===== sv/hs_store.sv =====
module hs_store #(
    parameter int DEPTH = hs_pkg::MAX_ITEMS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  hs_pkg::t_word            i_wdata,
    input  logic                     i_re_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    output hs_pkg::t_word            o_rdata_a,
    input  logic                     i_re_b,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output hs_pkg::t_word            o_rdata_b
);

    hs_pkg::t_word r_mem [DEPTH];
    hs_pkg::t_word r_rd_a;
    hs_pkg::t_word r_rd_b;

    // One write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Two read ports, registered, data held while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re_a) begin
            r_rd_a <= r_mem[i_raddr_a];
        end
        if (i_re_b) begin
            r_rd_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rd_a;
    assign o_rdata_b = r_rd_b;

endmodule

// ===== sv/hs_cmp.sv =====
module hs_cmp (
    input  hs_pkg::t_word    i_left,
    input  hs_pkg::t_word    i_right,
    input  hs_pkg::t_word    i_cur,
    input  logic             i_right_ok,
    output hs_pkg::t_cmp_res o_res
);

    logic w_gt_rl;
    logic w_gt_lc;
    logic w_gt_rc;

    // Three signed compares side by side, then select
    assign w_gt_rl = i_right > i_left;
    assign w_gt_lc = i_left > i_cur;
    assign w_gt_rc = i_right > i_cur;

    // Left wins ties, as does the carried value
    assign o_res.pick_right = i_right_ok && w_gt_rl;
    assign o_res.swap       = o_res.pick_right ? w_gt_rc : w_gt_lc;

endmodule

// ===== bench/heap_sorter_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels of heap_sorter, predicts the sorted output of every
// set and compares each result beat against the oldest prediction.
module heap_sorter_checker #(
    parameter int MAX_ITEMS = hs_pkg::MAX_ITEMS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      s_axis_tvalid,
    input  logic                      s_axis_tready,
    input  logic [hs_pkg::DATA_W-1:0] s_axis_tdata,   // [31:0] value
    input  logic                      s_axis_tlast,
    input  logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    input  logic [hs_pkg::DATA_W-1:0] m_axis_tdata,   // [31:0] sorted_value
    input  logic                      m_axis_tlast,
    input  logic                      m_axis_tuser,   // [0] overflow
    output int                        o_fail_count,
    output int                        o_pending
);

    // One predicted result beat
    typedef struct packed {
        hs_pkg::t_word value;
        logic          fin;
        logic          ovf;
    } t_sorted_beat;

    hs_pkg::t_word held_vals [MAX_ITEMS];
    int            held_cnt;
    logic          dropped;
    t_sorted_beat  sorted_due [$];
    int            fails;

    initial begin
        held_cnt = 0;
        dropped  = 1'b0;
        fails    = 0;
    end

    always @(posedge i_clk) begin
        t_sorted_beat  due;
        hs_pkg::t_word key;
        int            i;
        int            j;
        if (!i_rst_n) begin
            held_cnt = 0;
            dropped  = 1'b0;
            sorted_due.delete();
        end else begin
            // result beat: must match the oldest prediction
            if (m_axis_tvalid && m_axis_tready) begin
                if (sorted_due.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected result beat value %0d last %b ovf %b",
                             $time, $signed(m_axis_tdata), m_axis_tlast, m_axis_tuser);
                end else begin
                    due = sorted_due.pop_front();
                    if (m_axis_tdata !== due.value || m_axis_tlast !== due.fin ||
                        m_axis_tuser !== due.ovf) begin
                        fails++;
                        $display("%0t: expected %0d/%b/%b, got %0d/%b/%b (value/last/ovf)",
                                 $time, due.value, due.fin, due.ovf,
                                 $signed(m_axis_tdata), m_axis_tlast, m_axis_tuser);
                    end
                end
            end

            // input beat: collect, drop when full
            if (s_axis_tvalid && s_axis_tready) begin
                if (held_cnt < MAX_ITEMS) begin
                    held_vals[held_cnt] = s_axis_tdata;
                    held_cnt++;
                end else begin
                    dropped = 1'b1;
                end

                // end of set: ascending order, final mark on the largest
                if (s_axis_tlast) begin
                    for (i = 1; i < held_cnt; i++) begin
                        key = held_vals[i];
                        j   = i - 1;
                        while (j >= 0 && held_vals[j] > key) begin
                            held_vals[j+1] = held_vals[j];
                            j--;
                        end
                        held_vals[j+1] = key;
                    end
                    for (i = 0; i < held_cnt; i++) begin
                        due.value = held_vals[i];
                        due.fin   = (i == held_cnt - 1);
                        due.ovf   = dropped;
                        sorted_due.insert(sorted_due.size(), due);
                    end
                    held_cnt = 0;
                    dropped  = 1'b0;
                end
            end
        end
        o_pending    <= sorted_due.size();
        o_fail_count <= fails;
    end

endmodule

// ===== bench/heap_sorter_tb.sv =====
`timescale 1ns / 1ps

module heap_sorter_tb;

    localparam int N_MAX        = hs_pkg::MAX_ITEMS_DEF;
    localparam int RX_HOLD      = 3000;
    localparam int STALL_LIMIT  = 20000;
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASE_ITEMS  = 20;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      s_axis_tvalid;
    logic                      s_axis_tready;
    logic [hs_pkg::DATA_W-1:0] s_axis_tdata;    // [31:0] value
    logic                      s_axis_tlast;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready;
    logic [hs_pkg::DATA_W-1:0] m_axis_tdata;    // [31:0] sorted_value
    logic                      m_axis_tlast;
    logic                      m_axis_tuser;    // [0] overflow

    int fail_count;
    int pending;
    int items_sent = 0;
    int tx_idle_pct;
    int rx_stall_pct;
    int hold_req;
    int hold_seen;
    int quiet_cycles = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    heap_sorter #(
        .MAX_ITEMS (N_MAX)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    heap_sorter_checker #(
        .MAX_ITEMS (N_MAX)
    ) u_chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    // Watchdog: no beat on either channel for too long
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("heap_sorter_tb: FAIL");
                $finish;
            end
        end
    end

    // Result side: random stalls, plus one long hold-off on request
    initial begin
        m_axis_tready = 1'b0;
        hold_seen     = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                m_axis_tready <= 1'b0;
                repeat (RX_HOLD) @(posedge i_clk);
            end
            m_axis_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    // Value mix: extremes, a narrow band for repeats, full range
    function automatic hs_pkg::t_word pick_value();
        unique case ($urandom_range(0, 9))
            0:       return 32'h7fffffff;
            1:       return 32'h80000000;
            2, 3:    return hs_pkg::t_word'($urandom_range(0, 6)) - 3;
            default: return hs_pkg::t_word'($urandom);
        endcase
    endfunction

    task automatic send_beat(input hs_pkg::t_word value, input logic last);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic send_set(input int n);
        for (int k = 0; k < n; k++)
            send_beat(pick_value(), k == n - 1);
    endtask

    // Stop offering until every predicted result has been taken
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin
        int start;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        tx_idle_pct   = 0;
        rx_stall_pct  = 0;
        hold_req      = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // single-value sets at both extremes
        send_beat(32'h7fffffff, 1'b1);
        send_beat(32'h80000000, 1'b1);
        // extremes and values around zero in one set
        send_beat(32'h7fffffff, 1'b0);
        send_beat(32'h80000000, 1'b0);
        send_beat(32'h00000000, 1'b0);
        send_beat(32'hffffffff, 1'b0);
        send_beat(32'h00000001, 1'b1);
        // repeated values
        send_beat(32'd5, 1'b0);
        send_beat(32'd5, 1'b0);
        send_beat(-32'sd5, 1'b0);
        send_beat(32'd5, 1'b1);
        // already descending, already ascending
        send_beat(-32'sd1, 1'b0);
        send_beat(-32'sd2, 1'b1);
        send_beat(32'd1, 1'b0);
        send_beat(32'd2, 1'b0);
        send_beat(32'd3, 1'b0);
        send_beat(32'd4, 1'b1);
        drain_results();

        // long result hold-off: exactly full set, then one whose last beat
        // meets a full store, then a small set that backs up at the input
        hold_req <= hold_req + 1;
        send_set(N_MAX);
        send_set(N_MAX + 2);
        send_set(3);
        drain_results();

        // random sets under each idling pattern
        for (int p = 0; p < 4; p++) begin
            unique case (p)
                0: begin
                    tx_idle_pct = 0;
                    rx_stall_pct <= 0;
                end
                1: begin
                    tx_idle_pct = 46;
                    rx_stall_pct <= 0;
                end
                2: begin
                    tx_idle_pct = 0;
                    rx_stall_pct <= 46;
                end
                default: begin
                    tx_idle_pct = 21;
                    rx_stall_pct <= 21;
                end
            endcase
            start = items_sent;
            while (items_sent - start < PHASE_ITEMS) begin
                if ($urandom_range(0, 9) == 0)
                    send_set($urandom_range(N_MAX - 2, N_MAX + 4));
                else
                    send_set($urandom_range(1, 9));
            end
            drain_results();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("heap_sorter_tb: PASS");
        else
            $display("heap_sorter_tb: FAIL");
        $finish;
    end

endmodule
